### rtl/lqm_pkg.sv
// shared types and constants for the linear queue with maximum query
// no dependencies

package lqm_pkg;

  localparam int DEPTH  = 8;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_MAX    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    wr;
    logic    rd_head;
    logic    scan_start;
    logic    scan_step;
    logic    pop_take;
    logic    max_take;
    logic    res_set;
    status_e res_code;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       empty;
    logic       scan_more;
  } dp_sts_t;

endpackage

### rtl/linear_queue_with_max.sv
// top level of the linear queue with maximum query
// depends on lqm_pkg, lqm_ctrl and lqm_datapath
//
// usage:
//   input channel s_axis: tuser carries the operation (add, remove, max),
//   tdata the signed value to add. output channel m_axis: tdata carries the
//   removed value or the maximum (zero unless ok), tuser the status
//   (ok, full, empty). every input item yields exactly one output item.
//   one item is worked on at a time; the next is accepted once the current
//   result sits in the output register, even if the receiver has not taken it.
//   add, mode 3 and any empty or full case go from the exec state straight to
//   the done state; remove passes through the pop state, and max through the
//   scan state, which reads one slot per cycle through the single read port
//   of the slot ram, one slot for each entry held.
//   reset clears the head and tail positions, so the queue starts empty;
//   slot contents are not cleared. a stalled receiver holds the result in the
//   output register, and the block stops accepting once a second result waits.

module linear_queue_with_max import lqm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // value
  input  logic [1:0]        s_axis_tuser,  // mode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // data
  output logic [1:0]        m_axis_tuser   // status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lqm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_status_o(m_axis_tuser)
  );

  a_data_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("nonzero data with error status");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while another is in progress");

  a_not_full_and_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.full && sts.empty))
    else $error("queue positions not reset after last removal");

endmodule

### rtl/lqm_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies

module lqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                 wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/lqm_datapath.sv
// datapath: head and tail positions, slot ram, max accumulator and output registers
// depends on lqm_pkg and lqm_ram

module lqm_datapath import lqm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [1:0]        in_mode_i,
  input  logic [DATA_W-1:0] in_value_i,
  output logic [DATA_W-1:0] out_data_o,
  output logic [1:0]        out_status_o
);

  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [PTR_W-1:0]  scan_q, scan_d;
  logic              first_q, first_d;
  logic [1:0]        mode_q;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [DATA_W-1:0] out_data_q;
  logic [1:0]        out_status_q;
  logic [DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  head_inc;

  assign head_inc = PTR_W'(head_q + 1'b1);
  assign rd_addr  = cmd_i.scan_step ? scan_q[IDX_W-1:0] : head_q[IDX_W-1:0];

  lqm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.wr),
    .wr_addr_i(tail_q[IDX_W-1:0]),
    .wr_data_i(value_q),
    .rd_en_i  (cmd_i.rd_head | cmd_i.scan_step),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    scan_d       = scan_q;
    first_d      = first_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    if (cmd_i.wr) begin
      tail_d = PTR_W'(tail_q + 1'b1);
    end
    if (cmd_i.res_set) begin
      res_data_d   = '0;
      res_status_d = cmd_i.res_code;
    end
    if (cmd_i.scan_start) begin
      scan_d       = head_inc;
      first_d      = 1'b1;
      res_status_d = ST_OK;
    end
    if (cmd_i.scan_step) begin
      scan_d = PTR_W'(scan_q + 1'b1);
    end
    if (cmd_i.max_take) begin
      first_d = 1'b0;
      if (first_q || ($signed(rd_data) > $signed(res_data_q))) begin
        res_data_d = rd_data;
      end
    end
    if (cmd_i.pop_take) begin
      res_data_d   = rd_data;
      res_status_d = ST_OK;
      if (head_inc >= tail_q) begin
        head_d = '0;
        tail_d = '0;
      end else begin
        head_d = head_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      scan_q  <= '0;
      first_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      scan_q  <= scan_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_mode_i;
      value_q <= in_value_i;
    end
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    if (cmd_i.out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.full      = (tail_q >= PTR_W'(DEPTH));
  assign sts_o.empty     = (head_q >= tail_q) || (head_q >= PTR_W'(DEPTH));
  assign sts_o.scan_more = (scan_q < tail_q);
  assign out_data_o      = out_data_q;
  assign out_status_o    = out_status_q;

endmodule

### rtl/lqm_ctrl.sv
// controller: sequences one item at a time and drives the datapath commands
// depends on lqm_pkg

module lqm_ctrl import lqm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.res_code = ST_OK;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (sts_i.mode)
          MODE_ADD: begin
            cmd_o.res_set = 1'b1;
            if (sts_i.full) begin
              cmd_o.res_code = ST_FULL;
            end else begin
              cmd_o.wr = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (sts_i.empty) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = ST_EMPTY;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = S_POP;
            end
          end
          MODE_MAX: begin
            if (sts_i.empty) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = ST_EMPTY;
            end else begin
              cmd_o.rd_head    = 1'b1;
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
            cmd_o.res_set = 1'b1;
          end
        endcase
      end
      S_POP: begin
        cmd_o.pop_take = 1'b1;
        state_d        = S_DONE;
      end
      S_SCAN: begin
        cmd_o.max_take = 1'b1;
        if (sts_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
